/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the block checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

/* rtl/hrfc_pkg.sv */
// ----------------------------------------------------------------------------
// hrfc_pkg
// Types and constants for the header-resynchronised frame checksum block.
// ----------------------------------------------------------------------------
`default_nettype none

package hrfc_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 4;
    localparam int WORD_W   = 64;
    localparam int IDX_W    = 1;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0]  reg_idx_t;

    localparam reg_idx_t REG_HEADER_VALUE = 1'd0;
    localparam reg_idx_t REG_FRAME_LENGTH = 1'd1;

    localparam byte_t HEADER_RESET = 8'hFE;
    localparam len_t  LENGTH_RESET = 4'd8;
    localparam len_t  LENGTH_MIN   = 4'd2;

endpackage

`default_nettype wire

/* rtl/header_resync_frame_checksum.sv */
// ----------------------------------------------------------------------------
// header_resync_frame_checksum
// Collects bytes into fixed-length frames, resyncs on a header byte and
// forwards frames whose last byte equals the mod-256 sum of the others.
// ----------------------------------------------------------------------------
// Channel  Direction  Payload
// s_       in         tdata[7:0]  = rx_byte
// m_       out        tdata[63:0] = frame_word
// cfg_     in         index 0 header_value, index 1 frame_length
//
// One byte per cycle while s_tready is high: count, running sum and frame store update on accept.
// Frame word sits in an output register, valid in the cycle after the last byte is accepted.
// s_tready drops only while that register holds a request not yet taken.
// Reset clears count, sum and the output valid and loads the config registers with their reset values;
// the frame store is not cleared (only bytes written since the last restart are read).
// ----------------------------------------------------------------------------
`default_nettype none

module header_resync_frame_checksum #(
    parameter int MAX_FRAME_BYTES = 8
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire hrfc_pkg::reg_idx_t        cfg_index,
    input  wire hrfc_pkg::byte_t           cfg_data,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire hrfc_pkg::byte_t           s_tdata,   // [7:0] rx_byte
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output hrfc_pkg::word_t                m_tdata    // [63:0] frame_word
);

    localparam int CNT_W = (MAX_FRAME_BYTES > 2) ? $clog2(MAX_FRAME_BYTES) : 1;

    typedef logic [CNT_W-1:0] cnt_t;

    hrfc_pkg::byte_t  header_reg;
    hrfc_pkg::len_t   length_reg;
    cnt_t             count_reg, count_next;
    hrfc_pkg::byte_t  sum_reg, sum_next;
    hrfc_pkg::byte_t  frame_reg [MAX_FRAME_BYTES];
    logic             out_valid_reg, out_valid_next;
    hrfc_pkg::word_t  out_word_reg, out_word_next;

    hrfc_pkg::len_t   eff_len;
    logic             accept;
    logic             is_header;
    cnt_t             cnt_eff;
    hrfc_pkg::byte_t  sum_eff;
    logic             is_last;
    logic             sum_ok;
    hrfc_pkg::word_t  word_build;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;

    always_comb
    begin
        priority if (length_reg < hrfc_pkg::LENGTH_MIN)
        begin
            eff_len = hrfc_pkg::LENGTH_MIN;
        end
        else if (length_reg > hrfc_pkg::LEN_W'(MAX_FRAME_BYTES))
        begin
            eff_len = hrfc_pkg::LEN_W'(MAX_FRAME_BYTES);
        end
        else
        begin
            eff_len = length_reg;
        end
    end

    assign is_header = (s_tdata == header_reg);
    assign cnt_eff   = is_header ? '0 : count_reg;
    assign sum_eff   = is_header ? '0 : sum_reg;
    assign is_last   = (hrfc_pkg::LEN_W'(cnt_eff) + hrfc_pkg::LEN_W'(1)) == eff_len;
    assign sum_ok    = (sum_eff == s_tdata);

    always_comb
    begin
        word_build = '0;
        for (int k = 0; k < MAX_FRAME_BYTES; k++)
        begin
            if (cnt_t'(k) < cnt_eff)
            begin
                word_build[k*8 +: 8] = frame_reg[k];
            end
            else if (cnt_t'(k) == cnt_eff)
            begin
                word_build[k*8 +: 8] = s_tdata;
            end
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_word_next  = out_word_reg;
        if (accept)
        begin
            if (is_last)
            begin
                count_next = '0;
                sum_next   = '0;
                if (sum_ok)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = word_build;
                end
            end
            else
            begin
                count_next = cnt_eff + cnt_t'(1);
                sum_next   = sum_eff + s_tdata;
            end
        end
        if (cfg_we && (cfg_index == hrfc_pkg::REG_FRAME_LENGTH))
        begin
            count_next = '0;
            sum_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg    <= hrfc_pkg::HEADER_RESET;
            length_reg    <= hrfc_pkg::LENGTH_RESET;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    hrfc_pkg::REG_HEADER_VALUE: header_reg <= cfg_data;
                    hrfc_pkg::REG_FRAME_LENGTH: length_reg <= cfg_data[hrfc_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
        if (accept && !is_last)
        begin
            for (int k = 0; k < MAX_FRAME_BYTES; k++)
            begin
                if (cnt_eff == cnt_t'(k))
                begin
                    frame_reg[k] <= s_tdata;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/hrfc_checker.sv */
// ----------------------------------------------------------------------------
// hrfc_checker
// Port-level checks for header_resync_frame_checksum, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module hrfc_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire hrfc_pkg::word_t  m_tdata
);

    logic stall;
    logic take;

    assign stall = m_tvalid && !m_tready;
    assign take  = s_tvalid && s_tready;

    // stalled request holds its word
    `ASSERT_CLK(a_out_hold, clk, rst_n, stall |=> m_tvalid && $stable(m_tdata), "stalled word moved")

    // input side free whenever the output register can drain
    `ASSERT_CLK(a_ready_link, clk, rst_n, s_tready == !stall, "ready not tied to output")

    // a new frame word only follows an accepted byte
    `ASSERT_CLK(a_out_cause, clk, rst_n, m_tvalid && !$past(stall) |-> $past(take), "unsourced word")

    // nothing offered in reset
    `ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |-> !m_tvalid, "m_tvalid high in reset")

endmodule

bind header_resync_frame_checksum hrfc_checker u_hrfc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
